FILE: rtl/core/b64lw_pkg.sv
`timescale 1ns / 1ps
// Package for the line-wrapped base64 encoder.
// Holds the queue entry type, character constants and the digit encoder.
// No dependencies.
package b64lw_pkg;

    localparam int unsigned JobChars = 6;

    localparam logic [5:0] LineGroupsReset = 6'd18;

    localparam logic [7:0] ChPad = 8'h3D;
    localparam logic [7:0] ChCr  = 8'h0D;
    localparam logic [7:0] ChLf  = 8'h0A;

    // One accepted byte, expanded into the characters it causes.
    typedef struct packed {
        logic [JobChars-1:0][7:0] chars;
        logic [2:0]               cnt;
        logic                     fin;
    } t_job;

    // Standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [7:0] b64_digit(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26) begin
            ch = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            ch = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            ch = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            ch = 8'h2B;
        end else begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

endpackage

FILE: rtl/core/b64lw_front.sv
`timescale 1ns / 1ps
// Front end: accepts raw bytes, tracks group phase and line fill,
// and builds the character list for each byte. Uses b64lw_pkg.
module b64lw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [5:0]         i_line_groups,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data,
    input  logic               i_final,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output b64lw_pkg::t_job    o_job
);
    import b64lw_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic [5:0] r_gol,   n_gol;

    logic [3:0][7:0] list;
    logic [2:0]      list_len;
    logic [1:0]      ph_mid;
    logic [3:0]      carry_mid;
    logic [5:0]      pad6;
    logic [5:0]      gol_inc;
    logic [5:0]      gol_mid;
    logic            grp;
    logic            lg_on;
    logic            wrap;
    logic            crlf;
    logic            fire;

    assign o_ready     = i_job_ready;
    assign o_job_valid = i_valid;
    assign fire        = i_valid && i_job_ready;
    assign lg_on       = (i_line_groups != 6'd0);

    always_comb begin
        list[0]   = 8'h00;
        ph_mid    = 2'd0;
        carry_mid = 4'd0;
        pad6      = 6'd0;
        unique case (r_phase)
            2'd0: begin
                list[0]   = b64_digit(i_data[7:2]);
                carry_mid = {2'b00, i_data[1:0]};
                ph_mid    = 2'd1;
                pad6      = {i_data[1:0], 4'b0000};
            end
            2'd1: begin
                list[0]   = b64_digit({r_carry[1:0], i_data[7:4]});
                carry_mid = i_data[3:0];
                ph_mid    = 2'd2;
                pad6      = {i_data[3:0], 2'b00};
            end
            default: begin
                list[0]   = b64_digit({r_carry[3:0], i_data[7:6]});
                carry_mid = 4'd0;
                ph_mid    = 2'd0;
            end
        endcase

        list[1] = (r_phase == 2'd2 || r_phase == 2'd3) ? b64_digit(i_data[5:0])
                                                       : b64_digit(pad6);
        list[2] = ChPad;
        list[3] = ChPad;

        priority if (r_phase[1]) begin
            list_len = 3'd2;
        end else if (!i_final) begin
            list_len = 3'd1;
        end else if (r_phase == 2'd0) begin
            list_len = 3'd4;
        end else begin
            list_len = 3'd3;
        end

        // a group closes on phase 2 or on any final byte
        grp     = r_phase[1] || i_final;
        gol_inc = r_gol + 6'd1;
        wrap    = grp && lg_on && (gol_inc >= i_line_groups);
        if (grp && lg_on) begin
            gol_mid = wrap ? 6'd0 : gol_inc;
        end else begin
            gol_mid = r_gol;
        end
        crlf = wrap || (i_final && lg_on && (gol_mid != 6'd0));

        for (int i = 0; i < JobChars; i++) begin
            if (i < 4 && 3'(i) < list_len) begin
                o_job.chars[i] = list[i[1:0]];
            end else if (3'(i) == list_len) begin
                o_job.chars[i] = ChCr;
            end else begin
                o_job.chars[i] = ChLf;
            end
        end
        o_job.cnt = list_len + (crlf ? 3'd2 : 3'd0);
        o_job.fin = i_final;

        n_phase = i_final ? 2'd0 : ph_mid;
        n_carry = i_final ? 4'd0 : carry_mid;
        n_gol   = i_final ? 6'd0 : gol_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_carry <= 4'd0;
            r_gol   <= 6'd0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
            r_gol   <= n_gol;
        end
    end

endmodule

FILE: rtl/core/b64lw_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of character jobs between front and back end.
// Uses b64lw_pkg for the entry type.
module b64lw_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  b64lw_pkg::t_job i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output b64lw_pkg::t_job o_pop_data
);
    import b64lw_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: rtl/core/b64lw_back.sv
`timescale 1ns / 1ps
// Back end: takes queued jobs and sends their characters one per cycle
// while not stalled, via a registered output stage. Uses b64lw_pkg.
module b64lw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    output logic            o_job_ready,
    input  b64lw_pkg::t_job i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_char,
    output logic            o_run_last,
    output logic            o_msg_end
);
    import b64lw_pkg::*;

    t_job       r_job;
    logic       r_busy;
    logic [2:0] r_idx;
    logic       r_ovalid;
    logic [7:0] r_char;
    logic       r_last;
    logic       r_end;
    logic       adv;
    logic       last_c;

    assign adv         = r_busy && (!r_ovalid || i_ready);
    assign last_c      = (r_idx == r_job.cnt - 3'd1);
    assign o_job_ready = !r_busy || (adv && last_c);

    assign o_valid    = r_ovalid;
    assign o_char     = r_char;
    assign o_run_last = r_last;
    assign o_msg_end  = r_end;

    always_ff @(posedge i_clk) begin
        if (o_job_ready && i_job_valid) begin
            r_job <= i_job;
        end
        if (adv) begin
            r_char <= r_job.chars[r_idx];
            r_last <= last_c;
            r_end  <= last_c && r_job.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_job_ready && i_job_valid) begin
                r_busy <= 1'b1;
                r_idx  <= 3'd0;
            end else if (adv && last_c) begin
                r_busy <= 1'b0;
            end else if (adv) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

endmodule

FILE: rtl/core/base64_encoder_line_wrapped.sv
`timescale 1ns / 1ps
// Base64 encoder with CR LF line wrapping; top level of front, queue, back.
// Each byte's characters pass through the queue, a job register and an output register.
// One byte per cycle enters a 2-deep queue while it has room; the output sends
// one character per cycle unless stalled; a byte yields 1 to 6 chars (~1.4 avg).
// Reset (synchronous, active low) clears phase, line count and queue; line_groups = 18.
module base64_encoder_line_wrapped (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data,       // line_groups
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // data_byte
    input  logic       i_s_axis_tlast,   // final_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // out_char
    output logic       o_m_axis_tlast,   // run_last
    output logic [0:0] o_m_axis_tuser    // message_end
);
    import b64lw_pkg::*;

    logic [5:0] r_line_groups;
    logic       f_valid;
    logic       f_ready;
    t_job       f_job;
    logic       q_valid;
    logic       q_ready;
    t_job       q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_groups <= LineGroupsReset;
        end else if (i_cfg_valid) begin
            r_line_groups <= i_cfg_data;
        end
    end

    b64lw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_groups (r_line_groups),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_data        (i_s_axis_tdata),
        .i_final       (i_s_axis_tlast),
        .o_job_valid   (f_valid),
        .i_job_ready   (f_ready),
        .o_job         (f_job)
    );

    b64lw_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_job)
    );

    b64lw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_char      (o_m_axis_tdata),
        .o_run_last  (o_m_axis_tlast),
        .o_msg_end   (o_m_axis_tuser[0])
    );

endmodule

FILE: rtl/core/b64lw_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the line-wrapped base64 encoder, bound to the top.
// Depends on the top-level ports and b64lw_pkg.
module b64lw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic [0:0] o_m_axis_tuser
);
    import b64lw_pkg::*;

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tlast)
        else $error("message end without run end");

    a_cr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata == ChCr) |-> !o_m_axis_tlast)
        else $error("CR ends a run");

    a_pad_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata == ChPad) && o_m_axis_tlast
        |-> o_m_axis_tuser[0])
        else $error("pad ends a non-final run");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output changed while stalled");

endmodule

bind base64_encoder_line_wrapped b64lw_checker u_b64lw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for base64_encoder_line_wrapped: directed table, then random
// messages under several line widths, with bursty input and a stalling output side.
// Depends on b64lw_pkg and the encoder RTL only.
module testbench;
    import b64lw_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
    } t_char_rec;

    typedef struct {
        int         set_width;   // -1 keeps the current line width
        logic [7:0] data;
        logic       fin;
        string      want;        // empty with no break: predictor decides
        logic       want_break;
    } t_dir_row;

    localparam string Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int NumRows = 25;
    localparam int NumPhases = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [5:0] i_cfg_data = '0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = '0;
    logic       i_s_axis_tlast = 1'b0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;
    logic [0:0] o_m_axis_tuser;

    // encoder state as predicted
    logic [5:0] wrap_groups = LineGroupsReset;
    logic [1:0] byte_slot = '0;
    logic [3:0] spare_bits = '0;
    logic [5:0] line_fill = '0;
    logic [7:0] step_chars[$];
    t_char_rec  pending_chars[$];

    // typed expectation for the directed row on the bus
    logic       typed_on = 1'b0;
    string      typed_str = "";
    logic       typed_break = 1'b0;

    int         errors = 0;
    int         burst_left = 0;
    int         holds_asked = 0;
    int         holds_done = 0;
    int         hold_left = 0;
    int         mode_left = 0;
    int         rx_mode = 0;
    int         msg_left = 0;
    t_dir_row   dir_rows[NumRows];
    int         width_plan[NumPhases];

    base64_encoder_line_wrapped dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("base64_encoder_line_wrapped verification failed");
        $finish;
    end

    function automatic logic [7:0] digit_char(input logic [5:0] v);
        return Alphabet[v];
    endfunction

    function automatic void close_group();
        if (wrap_groups != 6'd0) begin
            line_fill = line_fill + 6'd1;
            if (line_fill >= wrap_groups) begin
                step_chars.push_back(ChCr);
                step_chars.push_back(ChLf);
                line_fill = '0;
            end
        end
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        t_char_rec rec;
        step_chars.delete();
        case (byte_slot)
            2'd0: begin
                step_chars.push_back(digit_char(b[7:2]));
                spare_bits = {2'b00, b[1:0]};
                byte_slot = 2'd1;
            end
            2'd1: begin
                step_chars.push_back(digit_char({spare_bits[1:0], b[7:4]}));
                spare_bits = b[3:0];
                byte_slot = 2'd2;
            end
            default: begin
                step_chars.push_back(digit_char({spare_bits, b[7:6]}));
                step_chars.push_back(digit_char(b[5:0]));
                spare_bits = '0;
                byte_slot = 2'd0;
                close_group();
            end
        endcase
        if (fin) begin
            if (byte_slot == 2'd1) begin
                step_chars.push_back(digit_char({spare_bits[1:0], 4'b0000}));
                step_chars.push_back(ChPad);
                step_chars.push_back(ChPad);
                close_group();
            end else if (byte_slot == 2'd2) begin
                step_chars.push_back(digit_char({spare_bits, 2'b00}));
                step_chars.push_back(ChPad);
                close_group();
            end
            if (wrap_groups != 6'd0 && line_fill != 6'd0) begin
                step_chars.push_back(ChCr);
                step_chars.push_back(ChLf);
            end
            byte_slot = '0;
            spare_bits = '0;
            line_fill = '0;
        end
        if (typed_on) begin
            step_chars.delete();
            for (int i = 0; i < typed_str.len(); i++) begin
                step_chars.push_back(typed_str[i]);
            end
            if (typed_break) begin
                step_chars.push_back(ChCr);
                step_chars.push_back(ChLf);
            end
        end
        foreach (step_chars[i]) begin
            rec.ch = step_chars[i];
            rec.run_last = (i == step_chars.size() - 1);
            rec.msg_end = fin && (i == step_chars.size() - 1);
            pending_chars.push_back(rec);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_char_rec want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                wrap_groups = i_cfg_data;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                encode_byte(i_s_axis_tdata, i_s_axis_tlast);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch("unexpected char", o_m_axis_tdata, 0);
                end else begin
                    want = pending_chars.pop_front();
                    if (o_m_axis_tdata !== want.ch) begin
                        report_mismatch("out_char", o_m_axis_tdata, want.ch);
                    end
                    if (o_m_axis_tlast !== want.run_last) begin
                        report_mismatch("run_last", o_m_axis_tlast, want.run_last);
                    end
                    if (o_m_axis_tuser[0] !== want.msg_end) begin
                        report_mismatch("message_end", o_m_axis_tuser[0], want.msg_end);
                    end
                end
            end
        end
    end

    // output side: stall modes of varying length, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (holds_done != holds_asked) begin
            hold_left = 400;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            case (rx_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= ($urandom_range(0, 1) == 0);
                2: i_m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: i_m_axis_tready <= !i_m_axis_tready;
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic use_typed,
                             input string want, input logic want_break);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        typed_on = use_typed;
        typed_str = want;
        typed_break = want_break;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        i_s_axis_tlast <= fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_line_groups(input logic [5:0] v);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_length();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(13, 40);
        end
        return $urandom_range(1, 12);
    endfunction

    initial begin
        int budget;
        dir_rows = '{
            '{-1, 8'h00, 1'b1, "AA==", 1'b1},
            '{-1, 8'hFF, 1'b1, "/w==", 1'b1},
            '{-1, 8'hFF, 1'b0, "/",    1'b0},
            '{-1, 8'hFF, 1'b1, "/8=",  1'b1},
            '{-1, 8'h00, 1'b0, "A",    1'b0},
            '{-1, 8'h00, 1'b0, "A",    1'b0},
            '{-1, 8'h00, 1'b1, "AA",   1'b1},
            '{-1, 8'h4D, 1'b0, "",     1'b0},
            '{-1, 8'h61, 1'b0, "",     1'b0},
            '{-1, 8'h6E, 1'b0, "",     1'b0},
            '{-1, 8'hFF, 1'b1, "",     1'b0},
            '{1,  8'h4D, 1'b1, "TQ==", 1'b1},  // wrap and closing break coincide
            '{-1, 8'h4D, 1'b0, "T",    1'b0},
            '{-1, 8'h61, 1'b0, "W",    1'b0},
            '{-1, 8'h6E, 1'b1, "Fu",   1'b1},  // ends on a group boundary at line start
            '{0,  8'h4D, 1'b0, "T",    1'b0},  // line breaks off
            '{-1, 8'h61, 1'b0, "W",    1'b0},
            '{-1, 8'h6E, 1'b0, "Fu",   1'b0},
            '{-1, 8'h00, 1'b1, "AA==", 1'b0},
            '{18, 8'h01, 1'b0, "",     1'b0},
            '{-1, 8'h02, 1'b0, "",     1'b0},
            '{-1, 8'h03, 1'b0, "",     1'b0},
            '{1,  8'h04, 1'b0, "",     1'b0},  // width lowered to the line fill
            '{-1, 8'h05, 1'b0, "",     1'b0},
            '{-1, 8'hC6, 1'b1, "",     1'b0}
        };
        width_plan = '{63, 0, 1, 2, 3, 18, 0, 0};
        width_plan[6] = $urandom_range(4, 62);
        width_plan[7] = $urandom_range(0, 63);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].set_width >= 0) begin
                set_line_groups(dir_rows[r].set_width[5:0]);
            end
            send_byte(dir_rows[r].data, dir_rows[r].fin,
                      dir_rows[r].want.len() != 0 || dir_rows[r].want_break,
                      dir_rows[r].want, dir_rows[r].want_break);
        end

        for (int p = 0; p < NumPhases; p++) begin
            set_line_groups(width_plan[p][5:0]);
            budget = 19;
            if (p == 5) begin
                // long enough to wrap an 18-group line
                msg_left = 56;
                budget = 60;
            end
            if (p == 2) begin
                holds_asked++;
            end
            for (int i = 0; i < budget; i++) begin
                if (p == 5 && i == budget / 2) begin
                    drain_results();
                end
                if (msg_left == 0) begin
                    msg_left = pick_length();
                end
                send_byte(8'($urandom_range(0, 255)), msg_left == 1, 1'b0, "", 1'b0);
                msg_left--;
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("base64_encoder_line_wrapped verification clean");
        end else begin
            $display("base64_encoder_line_wrapped verification failed");
        end
        $finish;
    end

endmodule

FILE: base64_encoder_line_wrapped.f
rtl/core/b64lw_pkg.sv
rtl/core/b64lw_front.sv
rtl/core/b64lw_fifo.sv
rtl/core/b64lw_back.sv
rtl/core/base64_encoder_line_wrapped.sv
rtl/core/b64lw_checker.sv
verif/testbench.sv
